@@ design/mhpq_pkg.sv @@
// Shared types and constants for the max-heap priority queue.
// Holds opcode, status and sequencer codes and the result record.
// No dependencies; imported by every module of the block but the memory.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    // fixed widths of the stream fields
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = 2 * VALUE_W + COUNT_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // sift sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_LAST,
        S_DN,
        S_DN_CMP,
        S_FIN
    } state_t;

    // one finished result, handed from the sequencer to the output stage
    typedef struct packed {
        logic [VALUE_W-1:0] removed_value;
        logic [VALUE_W-1:0] top_value;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

@@ design/mhpq_ram.sv @@
// Heap storage: one write port and two registered read ports.
// Read data is registered and appears in the cycle after the address. Standalone, no imports.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    ra_addr,
    output logic      [WIDTH-1:0] ra_data,
    input  wire logic [AW-1:0]    rb_addr,
    output logic      [WIDTH-1:0] rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // two read ports, registered
    always_ff @(posedge aclk) begin
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

`default_nettype wire

@@ design/mhpq_ctrl.sv @@
// Sift sequencer: walks the heap one level per read/compare pass,
// carrying the moving element in a register and writing back each level.
// Depends on mhpq_pkg and drives the ports of mhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl #(
    parameter int CAPACITY   = 128,
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 7,
    parameter int CW         = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    in_op,
    input  wire logic [mhpq_pkg::VALUE_W-1:0] in_value,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output mhpq_pkg::result_t            res,
    output logic                         mem_we,
    output logic [IW-1:0]                mem_waddr,
    output logic [DATA_WIDTH-1:0]        mem_wdata,
    output logic [IW-1:0]                mem_ra_addr,
    input  wire logic [DATA_WIDTH-1:0]   mem_ra_data,
    output logic [IW-1:0]                mem_rb_addr,
    input  wire logic [DATA_WIDTH-1:0]   mem_rb_data
);

    import mhpq_pkg::*;

    localparam int LW = IW + 2;

    state_t              state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;
    logic [DATA_WIDTH-1:0] top_reg;
    logic [VALUE_W-1:0]  removed_reg, removed_next;
    status_t             status_reg, status_next;

    logic [IW-1:0]       parent;
    logic [LW-1:0]       left, right, cnt_ext;
    logic                left_ok, right_ok;
    logic                up_swap, take_left, take_right;
    logic [DATA_WIDTH-1:0] cand_l;

    // sign-extend a stored element to the output field width
    function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] v);
        return VALUE_W'($signed(v));
    endfunction

    // tree addressing
    assign parent  = (idx_reg - IW'(1)) >> 1;
    assign left    = {1'b0, idx_reg, 1'b1};
    assign right   = left + LW'(1);
    assign cnt_ext = LW'(cnt_reg);
    assign left_ok  = left < cnt_ext;
    assign right_ok = right < cnt_ext;

    // compares: parent against carried value, children against carried value
    assign up_swap    = $signed(hold_reg) > $signed(mem_ra_data);
    assign take_left  = $signed(hold_reg) < $signed(mem_ra_data);
    assign cand_l     = take_left ? mem_ra_data : hold_reg;
    assign take_right = right_ok && ($signed(cand_l) < $signed(mem_rb_data));

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        hold_reg    <= hold_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        if (mem_we && mem_waddr == '0) begin
            top_reg <= mem_wdata;
        end
    end

    // next state, memory requests and result
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        hold_next    = hold_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = hold_reg;
        mem_ra_addr  = '0;
        mem_rb_addr  = '0;

        res.removed_value = removed_reg;
        res.top_value     = (cnt_reg != '0) ? to_out(top_reg) : '0;
        res.count         = COUNT_W'(cnt_reg);
        res.status        = status_reg;

        unique case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                mem_ra_addr = IW'(cnt_reg - CW'(1));
                if (in_valid) begin
                    removed_next = '0;
                    status_next  = STAT_OK;
                    if (opcode_t'(in_op) == OP_INSERT) begin
                        if (cnt_reg == CW'(CAPACITY)) begin
                            status_next = STAT_FULL;
                            state_next  = S_FIN;
                        end else begin
                            hold_next  = DATA_WIDTH'(in_value);
                            idx_next   = cnt_reg[IW-1:0];
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_UP;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = S_FIN;
                        end else begin
                            removed_next = to_out(top_reg);
                            cnt_next     = cnt_reg - CW'(1);
                            state_next   = (cnt_reg == CW'(1)) ? S_FIN : S_LAST;
                        end
                    end
                end
            end
            // sift up: reached root, or fetch the parent
            S_UP: begin
                mem_ra_addr = parent;
                if (idx_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (up_swap) begin
                    mem_wdata  = mem_ra_data;
                    idx_next   = parent;
                    state_next = S_UP;
                end else begin
                    state_next = S_FIN;
                end
            end
            // last element becomes the carried value, start at the root
            S_LAST: begin
                hold_next  = mem_ra_data;
                idx_next   = '0;
                state_next = S_DN;
            end
            // sift down: stop at a leaf, or fetch both children
            S_DN: begin
                mem_ra_addr = left[IW-1:0];
                mem_rb_addr = right_ok ? right[IW-1:0] : left[IW-1:0];
                if (!left_ok) begin
                    mem_we     = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                priority if (take_right) begin
                    mem_wdata  = mem_rb_data;
                    idx_next   = right[IW-1:0];
                    state_next = S_DN;
                end else if (take_left) begin
                    mem_wdata  = mem_ra_data;
                    idx_next   = left[IW-1:0];
                    state_next = S_DN;
                end else begin
                    state_next = S_FIN;
                end
            end
            // hand the result to the output stage
            S_FIN: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/max_heap_priority_queue_unit.sv @@
// Binary max-heap priority queue with a streaming input and result channel.
// Input item: s_tuser is the opcode (0 insert, 1 remove the maximum), s_tdata
// the signed value to insert. Every accepted item yields exactly one result
// item on the m_ side: removed value, new top, element count and status
// (0 ok, 1 remove on empty, 2 insert on full; a flagged item leaves the heap as it was).
// Elements live in a two-read, one-write memory with registered reads; the
// sequencer sifts one tree level per pass (read, then compare and write).
// One item is in the sequencer at a time; s_tready is high while it is idle,
// so the next item is taken in the cycle after a result is handed over.
// A result waits in the output register while the next item is taken and
// sifted; if the receiver holds m_tready low the sequencer waits with its
// finished result until the register frees, and s_tready stays low.
// Synchronous active-low reset empties the heap and clears both channels;
// no memory sweep is needed since only entries below the count are read.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue_unit #(
    parameter int CAPACITY   = 128,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mhpq_pkg::VALUE_W-1:0]   s_tdata,  // value
    input  wire logic                           s_tuser,  // opcode
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [mhpq_pkg::OUT_W-1:0]          m_tdata,  // removed_value, top_value, count
    output logic [mhpq_pkg::STAT_W-1:0]         m_tuser   // status
);

    import mhpq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  res_valid, res_ready;
    result_t               res;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr, mem_ra_addr, mem_rb_addr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_ra_data, mem_rb_data;

    logic                  m_tvalid_reg, m_tvalid_next;
    result_t               out_reg;

    mhpq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_value    (s_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_ra_addr (mem_ra_addr),
        .mem_ra_data (mem_ra_data),
        .mem_rb_addr (mem_rb_addr),
        .mem_rb_data (mem_rb_data)
    );

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (mem_ra_addr),
        .ra_data (mem_ra_data),
        .rb_addr (mem_rb_addr),
        .rb_data (mem_rb_data)
    );

    // output register loads whenever it is empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.count, out_reg.top_value, out_reg.removed_value};
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

@@ design/mhpq_checker.sv @@
// Port-level checks on the result channel of the heap queue.
// Depends on mhpq_pkg; bound to max_heap_priority_queue_unit below.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mhpq_pkg::OUT_W-1:0]    m_tdata,
    input wire logic [mhpq_pkg::STAT_W-1:0]   m_tuser
);

    import mhpq_pkg::*;

    // a remove on an empty heap reports nothing removed, no top and no elements
    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_EMPTY) |-> (m_tdata == '0))
        else $error("empty status with nonzero fields");

    // a rejected insert removes nothing and reports a nonzero element count
    a_full_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_FULL) |->
            (m_tdata[VALUE_W-1:0] == '0 && m_tdata[OUT_W-1:2*VALUE_W] != '0))
        else $error("full status with inconsistent fields");

    // an empty heap never reports a top value
    a_top_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_W-1:2*VALUE_W] == '0) |->
            (m_tdata[2*VALUE_W-1:VALUE_W] == '0))
        else $error("top value reported on empty heap");

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result item changed while stalled");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ sim/heap_result_checker.sv @@
// Result checker for the max-heap priority queue: watches both stream channels,
// keeps its own heap to predict each result item and compares it field by field.
// Depends on mhpq_pkg for the opcode and status codes and the field widths.
`timescale 1ns / 1ps

module heap_result_checker #(
    parameter int CAPACITY = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [mhpq_pkg::VALUE_W-1:0]  s_tdata,   // value
    input  logic                          s_tuser,   // opcode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [mhpq_pkg::OUT_W-1:0]    m_tdata,   // removed_value, top_value, count
    input  logic [mhpq_pkg::STAT_W-1:0]   m_tuser,   // status
    output int                            fail_count,
    output int                            results_owed
);
    import mhpq_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] removed;
        logic [VALUE_W-1:0] top;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } heap_result_t;

    // shadow heap, only entries below held are ever read
    logic signed [VALUE_W-1:0] slots [CAPACITY];
    int unsigned               held;
    heap_result_t              owed_results [$];
    int                        errs;
    int                        result_no;

    initial begin
        held      = 0;
        errs      = 0;
        result_no = 0;
    end

    // swap two heap slots
    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic signed [VALUE_W-1:0] t;
        t        = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
    endfunction

    // apply one insert or remove-max to the shadow heap and build its result
    function automatic heap_result_t apply_heap_op(opcode_t op, logic signed [VALUE_W-1:0] v);
        heap_result_t r;
        int unsigned  i;
        int unsigned  p;
        int unsigned  l;
        int unsigned  big;
        r.removed = '0;
        r.top     = '0;
        r.status  = STAT_OK;
        if (op == OP_INSERT) begin
            if (held >= CAPACITY) begin
                r.status = STAT_FULL;
            end else begin
                // place in the first free slot, sift up past strictly smaller parents
                i        = held;
                slots[i] = v;
                held++;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (slots[p] < slots[i]) begin
                        swap_slots(p, i);
                        i = p;
                    end else begin
                        break;
                    end
                end
            end
        end else begin
            if (held == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.removed = slots[0];
                held--;
                if (held > 0) begin
                    // last element to the root, sift down toward the larger child
                    slots[0] = slots[held];
                    i = 0;
                    forever begin
                        l = 2 * i + 1;
                        if (l >= held) break;
                        big = i;
                        if (slots[big] < slots[l]) big = l;
                        if (l + 1 < held && slots[big] < slots[l + 1]) big = l + 1;
                        if (big == i) break;
                        swap_slots(i, big);
                        i = big;
                    end
                end
            end
        end
        if (held > 0) r.top = slots[0];
        r.count = COUNT_W'(held);
        return r;
    endfunction

    // count a wrong field, report the first few
    task automatic flag_field(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        errs++;
        if (errs <= 10)
            $display("%0t: item %0d %s mismatch, expected %h got %h",
                     $time, result_no, what, want, got);
    endtask

    // predict on accepted input items, compare on accepted result items
    always @(posedge aclk) begin
        heap_result_t want;
        if (!aresetn) begin
            held = 0;
            owed_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                owed_results.push_back(apply_heap_op(opcode_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected result item %h / %h", $time, m_tdata, m_tuser);
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== want.removed)
                        flag_field("removed_value", want.removed, m_tdata[VALUE_W-1:0]);
                    if (m_tdata[2*VALUE_W-1:VALUE_W] !== want.top)
                        flag_field("top_value", want.top, m_tdata[2*VALUE_W-1:VALUE_W]);
                    if (m_tdata[OUT_W-1:2*VALUE_W] !== want.count)
                        flag_field("count", VALUE_W'(want.count), VALUE_W'(m_tdata[OUT_W-1:2*VALUE_W]));
                    if (m_tuser !== want.status)
                        flag_field("status", VALUE_W'(want.status), VALUE_W'(m_tuser));
                end
                result_no++;
            end
        end
        fail_count   <= errs;
        results_owed <= owed_results.size();
    end

endmodule

@@ sim/tb.sv @@
// Testbench top for max_heap_priority_queue_unit: clock, reset, stimulus and verdict.
// Drives directed then phased random insert/remove items with random idling on both sides.
// Depends on mhpq_pkg, the block itself and heap_result_checker.
`timescale 1ns / 1ps

module tb;
    import mhpq_pkg::*;

    localparam int CAPACITY   = 128;
    localparam int RAND_ITEMS = 850;
    localparam int QUIET_TAIL = 100;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    int                   fail_count;
    int                   results_owed;

    // occupancy as seen by the stimulus, used only to steer the phases
    int                   occupancy;
    int                   rand_sent;
    int                   full_hits;
    int                   empty_hits;
    bit                   idle_on;

    max_heap_priority_queue_unit #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(VALUE_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    heap_result_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .results_owed(results_owed)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard limit on run time
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall bursts while idling is on
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    end

    // values weighted toward ties, small numbers and the signed extremes
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return VALUE_W'($signed($urandom_range(0, 7)) - 4);
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default:       return 32'h8000_0000 ^ VALUE_W'($urandom_range(0, 3));
        endcase
    endfunction

    // one item: optional gap, then hold valid until the handshake
    task automatic send_item(opcode_t op, logic [VALUE_W-1:0] v);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_INSERT) begin
            if (occupancy == CAPACITY) full_hits++;
            else occupancy++;
        end else begin
            if (occupancy == 0) empty_hits++;
            else occupancy--;
        end
    endtask

    // random item with a given share of inserts; remove carries a junk value
    task automatic send_random(int insert_pct);
        opcode_t op;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        if (RAND_ITEMS - rand_sent <= QUIET_TAIL) idle_on = 1'b0;
        send_item(op, pick_value());
        rand_sent++;
    endtask

    // fill until several inserts bounce off a full heap
    task automatic fill_phase();
        int target;
        target    = $urandom_range(2, 5);
        full_hits = 0;
        while (full_hits < target && rand_sent < RAND_ITEMS) send_random(85);
    endtask

    // drain until several removes hit an empty heap
    task automatic drain_phase();
        int target;
        target     = $urandom_range(2, 5);
        empty_hits = 0;
        while (empty_hits < target && rand_sent < RAND_ITEMS) send_random(15);
    endtask

    // mixed phase of random length and balance
    task automatic mixed_phase();
        int len;
        int pct;
        len = $urandom_range(20, 60);
        pct = $urandom_range(30, 70);
        repeat (len) begin
            if (rand_sent < RAND_ITEMS) send_random(pct);
        end
    endtask

    // reset, stimulus and verdict
    initial begin
        int phase_no;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        aresetn   <= 1'b0;
        occupancy  = 0;
        rand_sent  = 0;
        full_hits  = 0;
        empty_hits = 0;
        idle_on    = 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: remove on empty, extremes, ties, drain to empty and past it
        send_item(OP_REMOVE, 32'hdead_beef);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'hffff_ffff);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'hffff_fffb);
        repeat (9) send_item(OP_REMOVE, 32'hffff_ffff);
        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_INSERT, 32'h5555_5555);
        send_item(OP_INSERT, 32'haaaa_aaaa);
        send_item(OP_REMOVE, 32'h1234_5678);

        // random: fill to full, drain to empty, then random phases
        phase_no = 0;
        while (rand_sent < RAND_ITEMS) begin
            idle_on = (RAND_ITEMS - rand_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            case (phase_no == 0 ? 0 : phase_no == 1 ? 1 : $urandom_range(0, 2))
                0:       fill_phase();
                1:       drain_phase();
                default: mixed_phase();
            endcase
            phase_no++;
        end
        s_tvalid <= 1'b0;
        idle_on   = 1'b0;

        // wait for every owed result, then for stray late ones
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fail_count == 0 && results_owed == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
